>>> sv/glyph_alpha_blend_pixel_defines.svh
// Assertion macros shared by the glyph blend RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef GLYPH_ALPHA_BLEND_PIXEL_DEFINES_SVH
`define GLYPH_ALPHA_BLEND_PIXEL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GABP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define GABP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define GABP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GABP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/gabp_pkg.sv
// Shared types, register map and arithmetic helpers for the glyph blend block.
// No dependencies.
package gabp_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CLIP_W     = 15;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned COV_W      = 8;
  localparam int unsigned LANES      = 4;

  localparam logic [7:0]  CHAN_MAX   = 8'hFF;
  localparam logic [14:0] CLIP_MAX   = 15'd32767;

  typedef enum logic [2:0] {
    REG_TEXT_COLOR  = 3'd0,
    REG_PIXEL_BYTES = 3'd1,
    REG_CLIP_LEFT   = 3'd2,
    REG_CLIP_TOP    = 3'd3,
    REG_CLIP_RIGHT  = 3'd4,
    REG_CLIP_BOTTOM = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FMT_RGB565 = 3'd2,
    FMT_RGB888 = 3'd3,
    FMT_RGBA   = 3'd4
  } pix_fmt_t;

  localparam logic [2:0] FMT_RESET = 3'd4;

  // floor(x / 255), exact for x < 65280 (results up to 255)
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  // floor((d*(255-a) + a*c) / 255)
  function automatic logic [7:0] mix(input logic [7:0] d, input logic [7:0] c,
                                     input logic [7:0] a);
    logic [15:0] pd;
    logic [15:0] pc;
    pd = d * (CHAN_MAX - a);
    pc = a * c;
    return div255(pd + pc);
  endfunction

endpackage

>>> sv/glyph_alpha_blend_pixel.sv
// Glyph coverage blend over a destination pixel stream, with clip test.
// Depends on gabp_pkg and glyph_alpha_blend_pixel_defines.svh.
//
//  channel  dir  handshake               payload
//  in_      in   in_tvalid/in_tready     tdata: coverage, dest_pixel, pos_x, pos_y
//  out_     out  out_tvalid/out_tready   tdata: new_pixel; tuser: write_enable
//  cfg      in   psel/penable/pready     six registers at 4*i, read as 32-bit words
//
// One beat per clock while out_tready is high; input register, then result register.
// Blend path: one 8x8 multiply pair and a divide-by-255 add per lane, four lanes.
// Reset clears the valid flags and loads the register defaults.
// A stalled result holds in the result register; the input register still
// refills when the result register drains in the same cycle.
`include "glyph_alpha_blend_pixel_defines.svh"
module glyph_alpha_blend_pixel
  import gabp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [71:0]           in_tdata,   // coverage[7:0], dest_pixel[39:8], pos_x[55:40], pos_y[71:56]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIXEL_W-1:0]    out_tdata,  // new_pixel[31:0]
  output logic                  out_tuser,  // write_enable[0]
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [31:0]       text_color_r;
  logic [2:0]        pixel_bytes_r;
  logic [CLIP_W-1:0] clip_left_r;
  logic [CLIP_W-1:0] clip_top_r;
  logic [CLIP_W-1:0] clip_right_r;
  logic [CLIP_W-1:0] clip_bottom_r;

  logic              cfg_wr;
  cfg_reg_t          cfg_sel;

  logic              s1_valid_r;
  logic [COV_W-1:0]  cov_r;
  logic [PIXEL_W-1:0] dest_r;
  logic [POS_W-1:0]  pos_x_r;
  logic [POS_W-1:0]  pos_y_r;

  logic              out_valid_r;
  logic [PIXEL_W-1:0] out_pixel_r;
  logic              out_we_r;

  logic              advance;
  logic              in_fire;
  logic              in_clip;
  logic [7:0]        lane_d [LANES];
  logic [7:0]        lane_c [LANES];
  logic [7:0]        lane_q [LANES];
  logic [PIXEL_W-1:0] out_pixel_nxt;
  logic              out_we_nxt;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r  <= '0;
      pixel_bytes_r <= FMT_RESET;
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_right_r  <= CLIP_MAX;
      clip_bottom_r <= CLIP_MAX;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_TEXT_COLOR:  text_color_r  <= pwdata;
        REG_PIXEL_BYTES: pixel_bytes_r <= pwdata[2:0];
        REG_CLIP_LEFT:   clip_left_r   <= pwdata[CLIP_W-1:0];
        REG_CLIP_TOP:    clip_top_r    <= pwdata[CLIP_W-1:0];
        REG_CLIP_RIGHT:  clip_right_r  <= pwdata[CLIP_W-1:0];
        REG_CLIP_BOTTOM: clip_bottom_r <= pwdata[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_TEXT_COLOR:  prdata = text_color_r;
      REG_PIXEL_BYTES: prdata = {29'd0, pixel_bytes_r};
      REG_CLIP_LEFT:   prdata = {17'd0, clip_left_r};
      REG_CLIP_TOP:    prdata = {17'd0, clip_top_r};
      REG_CLIP_RIGHT:  prdata = {17'd0, clip_right_r};
      REG_CLIP_BOTTOM: prdata = {17'd0, clip_bottom_r};
      default:         prdata = '0;
    endcase
  end

  // pipeline control
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cov_r   <= in_tdata[7:0];
      dest_r  <= in_tdata[39:8];
      pos_x_r <= in_tdata[55:40];
      pos_y_r <= in_tdata[71:56];
    end
  end

  // clip test: negative coordinates are always outside
  assign in_clip = !pos_x_r[POS_W-1] && !pos_y_r[POS_W-1]
                && (pos_x_r[CLIP_W-1:0] >= clip_left_r)
                && (pos_x_r[CLIP_W-1:0] <  clip_right_r)
                && (pos_y_r[CLIP_W-1:0] >= clip_top_r)
                && (pos_y_r[CLIP_W-1:0] <  clip_bottom_r);

  // steer channels onto the four blend lanes
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_d[k] = dest_r[8*k +: 8];
      lane_c[k] = text_color_r[8*k +: 8];
    end
    case (pix_fmt_t'(pixel_bytes_r))
      FMT_RGB565: begin
        lane_d[0] = {3'd0, dest_r[4:0]};
        lane_c[0] = {3'd0, text_color_r[4:0]};
        lane_d[1] = {2'd0, dest_r[10:5]};
        lane_c[1] = {2'd0, text_color_r[10:5]};
        lane_d[2] = {3'd0, dest_r[15:11]};
        lane_c[2] = {3'd0, text_color_r[15:11]};
      end
      FMT_RGB888: begin
        lane_c[0] = text_color_r[23:16];
        lane_c[2] = text_color_r[7:0];
      end
      default: ;
    endcase
    for (int k = 0; k < LANES; k++) begin
      lane_q[k] = mix(lane_d[k], lane_c[k], cov_r);
    end
  end

  always_comb begin
    out_pixel_nxt = dest_r;
    out_we_nxt    = 1'b0;
    if (in_clip && (cov_r != '0)) begin
      case (pix_fmt_t'(pixel_bytes_r))
        FMT_RGB565: begin
          out_pixel_nxt = {dest_r[31:16], lane_q[2][4:0], lane_q[1][5:0], lane_q[0][4:0]};
          out_we_nxt    = 1'b1;
        end
        FMT_RGB888: begin
          out_pixel_nxt = {dest_r[31:24], lane_q[2], lane_q[1], lane_q[0]};
          out_we_nxt    = 1'b1;
        end
        FMT_RGBA: begin
          out_pixel_nxt = {lane_q[3], lane_q[2], lane_q[1], lane_q[0]};
          out_we_nxt    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_pixel_r <= out_pixel_nxt;
      out_we_r    <= out_we_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tuser  = out_we_r;

  `GABP_ASSERT_NEXT(a_in_to_s1, clk, rst_n, in_fire, s1_valid_r)
  `GABP_ASSERT_NEXT(a_s1_to_out, clk, rst_n, s1_valid_r && advance, out_valid_r)
  `GABP_ASSERT_NEXT(a_drain, clk, rst_n, out_valid_r && out_tready && !s1_valid_r, !out_valid_r)
  `GABP_ASSERT_NEXT(a_zero_cov, clk, rst_n, s1_valid_r && advance && (cov_r == '0), !out_tuser)
  `GABP_ASSERT_SAME(a_ready, clk, rst_n, !s1_valid_r, in_tready)

endmodule
